// ----- sv/base32_stream_decoder_macros.svh -----
`ifndef BASE32_STREAM_DECODER_MACROS_SVH
`define BASE32_STREAM_DECODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define B32D_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b32d check failed");

// next-cycle implication, disabled in reset
`define B32D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b32d check failed");

`endif

// ----- sv/b32d_pkg.sv -----
package b32d_pkg;

   localparam int unsigned COUNT_BITS_DEFAULT = 16;
   localparam int unsigned SYMBOL_W           = 8;
   localparam int unsigned BYTE_W             = 8;
   localparam int unsigned TOTAL_W            = 16;
   localparam int unsigned LIMIT_W            = 16;
   localparam int unsigned ACC_W              = 12;
   localparam int unsigned HELD_W             = 4;
   localparam int unsigned VALUE_W            = 5;

   localparam logic [LIMIT_W-1:0]  MAX_OUT_RESET = 16'd90;
   localparam logic [SYMBOL_W-1:0] SYM_NUL       = 8'h00;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                end_of_string;
   } item_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_bytes;
      logic               done_res;
      logic               byte_valid;
      logic [BYTE_W-1:0]  out_byte;
   } result_type;

   // a..z -> 0..25, 0..5 -> 26..31, case-blind, anything else -> 0
   function automatic logic [VALUE_W-1:0] symbol_value(input logic [SYMBOL_W-1:0] c);
      logic [SYMBOL_W-1:0] diff;
      diff = '0;
      symbol_value = '0;
      if (c >= 8'h61 && c <= 8'h7a) begin
         diff = c - 8'h61;
         symbol_value = diff[VALUE_W-1:0];
      end else if (c >= 8'h41 && c <= 8'h5a) begin
         diff = c - 8'h41;
         symbol_value = diff[VALUE_W-1:0];
      end else if (c >= 8'h30 && c <= 8'h35) begin
         diff = c - 8'h30 + 8'd26;
         symbol_value = diff[VALUE_W-1:0];
      end
   endfunction

endpackage

// ----- sv/b32d_in_stage.sv -----
module b32d_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  b32d_pkg::item_type req_item,
   input  logic               down_ready,
   output logic               item_valid,
   output b32d_pkg::item_type item
);

   logic               full_ff;
   logic               full_in;
   b32d_pkg::item_type item_ff;
   logic               take;

   assign take       = full_ff && down_ready;
   assign req_tready = !full_ff || down_ready;
   assign item_valid = full_ff;
   assign item       = item_ff;

   always_comb begin
      full_in = full_ff;
      if (req_tvalid && req_tready) begin
         full_in = 1'b1;
      end else if (take) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

endmodule

// ----- sv/b32d_core.sv -----
module b32d_core #(
   parameter int unsigned COUNT_BITS = b32d_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [b32d_pkg::LIMIT_W-1:0]   csr_wr_data,
   input  logic                           take,
   input  b32d_pkg::item_type             item,
   output logic                           res_valid,
   output b32d_pkg::result_type           result
);

   localparam int unsigned CMP_W = (COUNT_BITS > b32d_pkg::LIMIT_W) ? COUNT_BITS
                                                                    : b32d_pkg::LIMIT_W;

   logic [b32d_pkg::LIMIT_W-1:0] limit_ff;
   logic [b32d_pkg::ACC_W-1:0]   acc_ff,     acc_in;
   logic [b32d_pkg::HELD_W-1:0]  held_ff,    held_in;
   logic [COUNT_BITS-1:0]        count_ff,   count_in;
   logic                         stopped_ff, stopped_in;

   logic [b32d_pkg::VALUE_W-1:0] sym_val;
   logic [b32d_pkg::ACC_W-1:0]   shifted;
   logic [b32d_pkg::ACC_W-1:0]   aligned;
   logic [b32d_pkg::ACC_W-1:0]   mask;
   logic [b32d_pkg::HELD_W-1:0]  sum_held;
   logic [b32d_pkg::HELD_W-1:0]  shift;
   logic [CMP_W-1:0]             count_cmp;
   logic [CMP_W-1:0]             limit_cmp;
   logic [CMP_W-1:0]             count_ext;
   logic                         emit;
   logic [b32d_pkg::BYTE_W-1:0]  byte_val;

   always_comb begin
      sym_val   = b32d_pkg::symbol_value(item.symbol);
      shifted   = {acc_ff[b32d_pkg::ACC_W-b32d_pkg::VALUE_W-1:0], sym_val};
      sum_held  = held_ff + 4'd5;
      shift     = sum_held - 4'd8;
      aligned   = shifted >> shift[2:0];
      mask      = (12'd1 << shift[2:0]) - 12'd1;
      count_cmp = CMP_W'(count_ff);
      limit_cmp = CMP_W'(limit_ff);

      acc_in     = acc_ff;
      held_in    = held_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      emit       = 1'b0;
      byte_val   = '0;

      if (!stopped_ff) begin
         if (item.symbol == b32d_pkg::SYM_NUL) begin
            stopped_in = 1'b1;
         end else begin
            acc_in  = shifted;
            held_in = sum_held;
            if (sum_held >= 4'd8) begin
               if (count_cmp < limit_cmp && !(&count_ff)) begin
                  byte_val = aligned[b32d_pkg::BYTE_W-1:0];
                  count_in = count_ff + COUNT_BITS'(1);
                  emit     = 1'b1;
                  acc_in   = shifted & mask;
                  held_in  = shift;
               end else begin
                  stopped_in = 1'b1;
               end
            end
         end
      end

      count_ext          = CMP_W'(count_in);
      res_valid          = emit || item.end_of_string;
      result.out_byte    = byte_val;
      result.byte_valid  = emit;
      result.done_res    = item.end_of_string;
      result.total_bytes = count_ext[b32d_pkg::TOTAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= b32d_pkg::MAX_OUT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         held_ff    <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (take) begin
         if (item.end_of_string) begin
            acc_ff     <= '0;
            held_ff    <= '0;
            count_ff   <= '0;
            stopped_ff <= 1'b0;
         end else begin
            acc_ff     <= acc_in;
            held_ff    <= held_in;
            count_ff   <= count_in;
            stopped_ff <= stopped_in;
         end
      end
   end

endmodule

// ----- sv/b32d_out_stage.sv -----
module b32d_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  b32d_pkg::result_type result,
   output logic                 up_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output b32d_pkg::result_type rsp_result
);

   logic                 full_ff;
   logic                 full_in;
   b32d_pkg::result_type result_ff;

   assign up_ready   = !full_ff || rsp_tready;
   assign rsp_tvalid = full_ff;
   assign rsp_result = result_ff;

   always_comb begin
      full_in = full_ff;
      if (load) begin
         full_in = 1'b1;
      end else if (rsp_tready) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

// ----- sv/base32_stream_decoder.sv -----
// channel  | dir | beat fields (low bit up)
// ---------+-----+-----------------------------------------------
// req_     | in  | tdata: symbol[7:0]; tlast: end_of_string
// rsp_     | out | tdata: out_byte[7:0], total_bytes[23:8];
//          |     | tuser: byte_valid; tlast: done_res
// csr_     | in  | wr_data: max_out_bytes, written when wr_en
//
// One character per cycle unless rsp_ stalls; req to rsp via both registers.
// Decode and string state update happen in one pass between the input
// register and the result register.
// Reset: synchronous, clears both stages, string state and sets limit to 90.
// A stalled rsp_ holds the result register; req_ keeps flowing into the
// input register until both registers are occupied.
module base32_stream_decoder #(
   parameter int unsigned COUNT_BITS = b32d_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // symbol
   input  logic                         req_tlast,   // end_of_string
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,   // out_byte, total_bytes
   output logic                         rsp_tuser,   // byte_valid
   output logic                         rsp_tlast,   // done_res
   input  logic                         csr_wr_en,
   input  logic [b32d_pkg::LIMIT_W-1:0] csr_wr_data
);

   b32d_pkg::item_type   req_item;
   b32d_pkg::item_type   item;
   b32d_pkg::result_type result;
   b32d_pkg::result_type rsp_result;
   logic                 item_valid;
   logic                 up_ready;
   logic                 take;
   logic                 res_valid;

   assign req_item.symbol        = req_tdata;
   assign req_item.end_of_string = req_tlast;
   assign take                   = item_valid && up_ready;

   b32d_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .down_ready (up_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   b32d_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .item        (item),
      .res_valid   (res_valid),
      .result      (result)
   );

   b32d_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take && res_valid),
      .result     (result),
      .up_ready   (up_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.total_bytes, rsp_result.out_byte};
   assign rsp_tuser = rsp_result.byte_valid;
   assign rsp_tlast = rsp_result.done_res;

endmodule

// ----- sv/b32d_checker.sv -----
`include "base32_stream_decoder_macros.svh"

module b32d_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [7:0]                   req_tdata,
   input logic                         req_tlast,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [23:0]                  rsp_tdata,
   input logic                         rsp_tuser,
   input logic                         rsp_tlast,
   input logic                         csr_wr_en,
   input logic [b32d_pkg::LIMIT_W-1:0] csr_wr_data
);

   logic rsp_stall;
   logic unused_ok;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign unused_ok = &{1'b0, req_tvalid, req_tready, req_tdata, req_tlast,
                        csr_wr_en, csr_wr_data};

   `B32D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid)
   `B32D_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall,
      $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `B32D_ASSERT_NOW(a_beat_has_purpose, clock, reset, rsp_tvalid,
      rsp_tuser || rsp_tlast)
   `B32D_ASSERT_NOW(a_no_byte_zero, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata[7:0] == 8'h00 && !unused_ok)
   `B32D_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid)

endmodule

bind base32_stream_decoder b32d_checker u_b32d_checker (.*);

// ----- bench/base32_decode_checker.sv -----
module base32_decode_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [7:0]                   req_tdata,
   input  logic                         req_tlast,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [23:0]                  rsp_tdata,
   input  logic                         rsp_tuser,
   input  logic                         rsp_tlast,
   input  logic                         csr_wr_en,
   input  logic [b32d_pkg::LIMIT_W-1:0] csr_wr_data,
   output int unsigned                  pending,
   output int unsigned                  failures
);
   timeunit 1ns;
   timeprecision 1ps;

   b32d_pkg::result_type                        due_results[$];
   logic [b32d_pkg::LIMIT_W-1:0]                byte_limit;
   logic [b32d_pkg::ACC_W-1:0]                  acc_bits;
   logic [b32d_pkg::HELD_W-1:0]                 acc_count;
   logic [b32d_pkg::COUNT_BITS_DEFAULT-1:0]     string_bytes;
   logic                                        string_halted;
   int unsigned                                 misses;

   initial begin
      misses = 0;
      pending = 0;
      failures = 0;
   end

   function automatic logic [b32d_pkg::VALUE_W-1:0] char_value(
      input logic [b32d_pkg::SYMBOL_W-1:0] c);
      logic [b32d_pkg::SYMBOL_W-1:0] v;
      v = 8'd0;
      if (c >= "a" && c <= "z") begin
         v = c - "a";
      end else if (c >= "A" && c <= "Z") begin
         v = c - "A";
      end else if (c >= "0" && c <= "5") begin
         v = c - "0" + 8'd26;
      end
      return v[b32d_pkg::VALUE_W-1:0];
   endfunction

   task automatic clear_string_state();
      acc_bits = '0;
      acc_count = '0;
      string_bytes = '0;
      string_halted = 1'b0;
   endtask

   task automatic decode_char(input logic [b32d_pkg::SYMBOL_W-1:0] sym, input logic last);
      b32d_pkg::result_type          r;
      logic                          emitted;
      logic [b32d_pkg::HELD_W-1:0]   shift;
      r = '0;
      emitted = 1'b0;
      if (!string_halted) begin
         if (sym == b32d_pkg::SYM_NUL) begin
            string_halted = 1'b1;
         end else begin
            acc_bits = {acc_bits[b32d_pkg::ACC_W-b32d_pkg::VALUE_W-1:0], char_value(sym)};
            acc_count = acc_count + 4'd5;
            if (acc_count >= 4'd8) begin
               shift = acc_count - 4'd8;
               if (string_bytes < byte_limit && string_bytes != '1) begin
                  r.out_byte = 8'(acc_bits >> shift);
                  string_bytes = string_bytes + 1'b1;
                  emitted = 1'b1;
                  acc_bits = acc_bits & ((12'd1 << shift) - 12'd1);
                  acc_count = shift;
               end else begin
                  string_halted = 1'b1;
               end
            end
         end
      end
      if (emitted || last) begin
         r.byte_valid = emitted;
         r.done_res = last;
         r.total_bytes = string_bytes[b32d_pkg::TOTAL_W-1:0];
         due_results.push_back(r);
      end
      if (last) begin
         clear_string_state();
      end
   endtask

   task automatic log_miss(input string msg);
      misses++;
      if (misses <= 10) begin
         $display("%0t checker: %s", $time, msg);
      end
   endtask

   task automatic check_beat();
      b32d_pkg::result_type seen;
      b32d_pkg::result_type due;
      seen.out_byte = rsp_tdata[7:0];
      seen.total_bytes = rsp_tdata[23:8];
      seen.byte_valid = rsp_tuser;
      seen.done_res = rsp_tlast;
      if (due_results.size() == 0) begin
         log_miss($sformatf("unexpected beat byte %h valid %b done %b total %0d",
            seen.out_byte, seen.byte_valid, seen.done_res, seen.total_bytes));
      end else begin
         due = due_results.pop_front();
         if (seen.out_byte !== due.out_byte || seen.byte_valid !== due.byte_valid ||
             seen.done_res !== due.done_res || seen.total_bytes !== due.total_bytes) begin
            log_miss($sformatf({"byte exp %h got %h, valid exp %b got %b, ",
               "done exp %b got %b, total exp %0d got %0d"},
               due.out_byte, seen.out_byte, due.byte_valid, seen.byte_valid,
               due.done_res, seen.done_res, due.total_bytes, seen.total_bytes));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         byte_limit = b32d_pkg::MAX_OUT_RESET;
         clear_string_state();
         due_results.delete();
      end else begin
         if (csr_wr_en) begin
            byte_limit = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_beat();
         end
      end
      pending <= due_results.size();
      failures <= misses;
   end

endmodule

// ----- bench/tb_base32_stream_decoder.sv -----
module tb_base32_stream_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [7:0]                    req_tdata;
   logic                          req_tlast;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [23:0]                   rsp_tdata;
   logic                          rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_wr_en;
   logic [b32d_pkg::LIMIT_W-1:0]  csr_wr_data;
   int unsigned                   pending;
   int unsigned                   failures;

   logic                          quiet;
   int unsigned                   hold_token;
   int unsigned                   sent_items;
   logic [b32d_pkg::LIMIT_W-1:0]  limit_steps[5];

   base32_stream_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   base32_decode_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .failures    (failures)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("tb_base32_stream_decoder: FAIL");
      $finish;
   end

   // result side: random backpressure plus one long hold on request
   initial begin : sink
      int unsigned hold_seen;
      int unsigned hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 12);
         end
      end
   end

   function automatic logic [7:0] pick_char();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45) return 8'("a" + $urandom_range(25));
      if (roll < 75) return 8'("A" + $urandom_range(25));
      if (roll < 90) return 8'("0" + $urandom_range(5));
      return 8'($urandom_range(255, 1));
   endfunction

   task automatic send_char(input logic [7:0] sym, input logic last);
      while (!quiet && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sym;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic send_string(input int unsigned len);
      int nul_at;
      nul_at = ($urandom_range(99) < 8) ? int'($urandom_range(len - 1)) : -1;
      for (int i = 0; i < len; i++) begin
         send_char((i == nul_at) ? b32d_pkg::SYM_NUL : pick_char(), i == len - 1);
         if (nul_at < 0 || i <= nul_at) sent_items++;
      end
   endtask

   task automatic run_strings(input int unsigned wanted, input int unsigned max_len);
      int unsigned target;
      target = sent_items + wanted;
      while (sent_items < target) begin
         send_string(($urandom_range(9) == 0) ? $urandom_range(max_len, 1)
                                              : $urandom_range(24, 1));
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(input logic [b32d_pkg::LIMIT_W-1:0] value);
      drain();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      quiet = 1'b0;
      hold_token = 0;
      sent_items = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("aZ5z0A~96");
      send_char(8'hff, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(8'h7f, 1'b0);
      send_char("m", 1'b1);
      send_char("m", 1'b0);
      send_char("z", 1'b0);
      send_char(b32d_pkg::SYM_NUL, 1'b0);
      send_char("q", 1'b1);
      send_char("q", 1'b1);
      send_char(b32d_pkg::SYM_NUL, 1'b1);

      quiet = 1'b1;
      run_strings(100, 24);
      quiet = 1'b0;
      // long strings run into the reset-time limit
      run_strings(250, 200);

      set_limit(16'hffff);
      run_strings(150, 40);

      limit_steps[0] = 16'd0;
      limit_steps[1] = 16'd1;
      limit_steps[2] = 16'd5;
      limit_steps[3] = 16'($urandom_range(30, 6));
      limit_steps[4] = 16'($urandom_range(65535));
      foreach (limit_steps[i]) begin
         set_limit(limit_steps[i]);
         if (i == 2) hold_token++;
         run_strings(150, 40);
      end

      drain();
      if (failures == 0) begin
         $display("tb_base32_stream_decoder: PASS");
      end else begin
         $display("tb_base32_stream_decoder: FAIL");
      end
      $finish;
   end

endmodule

// ----- base32_stream_decoder.f -----
+incdir+sv
sv/b32d_pkg.sv
sv/b32d_in_stage.sv
sv/b32d_core.sv
sv/b32d_out_stage.sv
sv/base32_stream_decoder.sv
sv/b32d_checker.sv
bench/base32_decode_checker.sv
bench/tb_base32_stream_decoder.sv
